// ----- hw/rtl/msd_pkg.sv -----
// msd_pkg: shared types and constants for the motor stall detector
// used by msd_cfg, msd_div and motor_stall_detector_unit
`timescale 1ns / 1ps

package msd_pkg;

  // configuration register widths and reset values
  localparam int LEARN_W = 10;
  localparam int RUN_W   = 8;
  localparam int LDIV_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEARN_W-1:0] LEARN_RESET = 10'd100;
  localparam logic [RUN_W-1:0]   TRIG_RESET  = 8'd3;
  localparam logic [LDIV_W-1:0]  LDIV_RESET  = 8'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_RUN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_DIVISOR  = 2'd2;

  // offset added to the scaled average to form the stall line
  localparam int LINE_OFFSET = 5;

  // saturation value of the low-sample run counter
  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_GO,
    S_AVG_WAIT,
    S_LINE_GO,
    S_LINE_WAIT,
    S_FINISH
  } msd_state_t;

endpackage

// ----- hw/rtl/motor_stall_detector_unit.sv -----
// motor_stall_detector_unit: top level of the motor stall detector
// depends on msd_pkg, msd_cfg and msd_div
`timescale 1ns / 1ps

// usage
// - input channel: in_valid / in_stall carry load_sample and restart; a
//   transfer happens when in_valid is high and in_stall is low
// - output channel: out_valid / out_stall carry stall_res, learning and
//   stall_level, one result per input transfer, in order
// - configuration: cfg_wr_en writes cfg_data into the register named by
//   cfg_index (0 learn_samples, 1 trigger_run, 2 line_divisor); write only
//   while the block is idle
// - a learning sample runs the shared serial divider twice: sum / count
//   takes SAMPLE_BITS + clog2(MAX_LEARN+1) steps, average / line_divisor
//   takes SAMPLE_BITS steps; the sequencer passes through the states
//   AVG_GO, AVG_WAIT, LINE_GO, LINE_WAIT and FINISH
// - restart and detection samples need no division and go straight to FINISH
// - in_stall stays high from the transfer until the result is loaded into
//   the output register; the next sample is taken while that result waits
// - when the receiver stalls, the result holds in the output register and
//   a following result waits in the finish state until the register frees
// - reset clears the learned sum, count, run counter and stall line and
//   loads the register defaults (100, 3, 2)

module motor_stall_detector_unit
  import msd_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int MAX_LEARN   = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] load_sample,
  input  logic                   restart,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   stall_res,
  output logic                   learning,
  output logic [SAMPLE_BITS:0]   stall_level
);

  localparam int COUNT_W = $clog2(MAX_LEARN + 1);
  localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
  localparam int TH_W    = SAMPLE_BITS + 1;
  localparam int DIV_W   = (COUNT_W > LDIV_W) ? COUNT_W : LDIV_W;
  localparam int CMP_W   = (COUNT_W > LEARN_W) ? COUNT_W : LEARN_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int PAD_W   = SUM_W - SAMPLE_BITS;

  // configuration registers
  logic [LEARN_W-1:0] learn_samples;
  logic [RUN_W-1:0]   trigger_run;
  logic [LDIV_W-1:0]  line_divisor;

  msd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .learn_samples (learn_samples),
    .trigger_run   (trigger_run),
    .line_divisor  (line_divisor)
  );

  // detector state
  logic [SUM_W-1:0]       sample_sum;
  logic [COUNT_W-1:0]     sample_count;
  logic [RUN_W-1:0]       low_run;
  logic [TH_W-1:0]        threshold;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   res_stall;
  logic                   res_learn;

  msd_state_t state, state_next;

  // shared divider hookup
  logic              div_start;
  logic [STEP_W-1:0] div_steps;
  logic [SUM_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [SUM_W-1:0]  div_quotient;
  logic              div_done;

  msd_div #(
    .DVD_W  (SUM_W),
    .DVS_W  (DIV_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  logic              in_xfer;
  logic              out_free;
  logic              learn_ok;
  logic              is_low;
  logic [LDIV_W-1:0] ldiv_eff;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // still learning while the count is within learn_samples and the hard cap
  assign learn_ok = (CMP_W'(sample_count) <= CMP_W'(learn_samples)) &&
                    (sample_count < COUNT_W'(MAX_LEARN));
  assign is_low   = ({1'b0, load_sample} <= threshold);
  // a zero divisor acts as one
  assign ldiv_eff = (line_divisor == '0) ? LDIV_W'(1) : line_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and divider controls
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_steps    = STEP_W'(SUM_W);
    div_dividend = sample_sum;
    div_divisor  = DIV_W'(sample_count);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!restart && learn_ok) begin
            state_next = S_AVG_GO;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_AVG_GO: begin
        // average = sum / count, full dividend width
        div_start  = 1'b1;
        state_next = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          state_next = S_LINE_GO;
        end
      end
      S_LINE_GO: begin
        // average sits in the top bits, so only SAMPLE_BITS steps are needed
        div_start    = 1'b1;
        div_steps    = STEP_W'(SAMPLE_BITS);
        div_dividend = {avg, {PAD_W{1'b0}}};
        div_divisor  = DIV_W'(ldiv_eff);
        state_next   = S_LINE_WAIT;
      end
      S_LINE_WAIT: begin
        if (div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // learned state, run counter and stall line
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      low_run      <= '0;
      threshold    <= '0;
    end else begin
      if (in_xfer) begin
        if (restart) begin
          sample_sum   <= '0;
          sample_count <= '0;
          low_run      <= '0;
          threshold    <= '0;
        end else if (learn_ok) begin
          sample_sum   <= sample_sum + SUM_W'(load_sample);
          sample_count <= sample_count + COUNT_W'(1);
        end else if (is_low) begin
          if (low_run != RUN_MAX) begin
            low_run <= low_run + RUN_W'(1);
          end
        end else begin
          low_run <= '0;
        end
      end
      if ((state == S_LINE_WAIT) && div_done) begin
        threshold <= {1'b0, div_quotient[SAMPLE_BITS-1:0]} + TH_W'(LINE_OFFSET);
      end
    end
  end

  // per-item result flags and the intermediate average
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_learn <= !restart && learn_ok;
      // stall only when the run steps onto trigger_run, never past saturation
      res_stall <= !restart && !learn_ok && is_low && (low_run != RUN_MAX) &&
                   ((low_run + RUN_W'(1)) == trigger_run);
    end
    if ((state == S_AVG_WAIT) && div_done) begin
      avg <= div_quotient[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      stall_res   <= res_stall;
      learning    <= res_learn;
      stall_level <= threshold;
    end
  end

endmodule

// ----- hw/rtl/msd_cfg.sv -----
// msd_cfg: configuration registers of the stall detector
// depends on msd_pkg for widths, indexes and reset values
`timescale 1ns / 1ps

module msd_cfg
  import msd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [LEARN_W-1:0]   learn_samples,
  output logic [RUN_W-1:0]     trigger_run,
  output logic [LDIV_W-1:0]    line_divisor
);

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_samples <= LEARN_RESET;
      trigger_run   <= TRIG_RESET;
      line_divisor  <= LDIV_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LEARN_SAMPLES: learn_samples <= cfg_data[LEARN_W-1:0];
        REG_TRIGGER_RUN:   trigger_run   <= cfg_data[RUN_W-1:0];
        REG_LINE_DIVISOR:  line_divisor  <= cfg_data[LDIV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/msd_div.sv -----
// msd_div: shared restoring divider, one quotient bit per cycle
// depends on msd_pkg only by convention; sized by its parameters
`timescale 1ns / 1ps

module msd_div
  import msd_pkg::*;
#(
  parameter int DVD_W  = 21,
  parameter int DVS_W  = 11,
  parameter int STEP_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic [DVD_W-1:0]  quotient,
  output logic              done
);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic           fits;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_sh  = {rem, dvd[DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule
